// ----- hw/rtl/stokes_parameter_integrator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Stokes integrator assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef STOKES_PARAMETER_INTEGRATOR_UNIT_DEFINES_SVH
`define STOKES_PARAMETER_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define SPIU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPIU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spiu_pkg.sv -----
// ----------------------------------------------------------------------------
// Stokes integrator package
// Widths, saturation limits, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package spiu_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int TERM_W       = PROD_W + 2;
  localparam int ACC_W        = 45;
  localparam int WIDE_W       = ACC_W + 2;
  localparam int DIV_W        = 7;
  localparam int STOKES_COUNT = 4;
  localparam int LANE_W       = $clog2(STOKES_COUNT);
  localparam int MAC_STEPS    = 8;
  localparam int MAC_W        = $clog2(MAC_STEPS);
  localparam int DIV_STEPS    = ACC_W;
  localparam int DCNT_W       = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic REG_ALL_STOKES = 1'b0;
  localparam logic REG_DIVISOR    = 1'b1;

  localparam logic [ACC_W-1:0] U_MAX = {ACC_W{1'b1}};
  localparam logic signed [WIDE_W-1:0] WIDE_U_MAX = {2'b00, {ACC_W{1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_S_MAX =
    {{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_S_MIN =
    {{(WIDE_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACCUM,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_PUBLISH
  } st_t;

  typedef struct packed {
    logic in_stall;
    logic accept;
    logic mac_en;
    logic accum_en;
    logic div_load;
    logic div_step;
    logic div_store;
    logic publish;
  } ctrl_t;

  function automatic logic [ACC_W-1:0] sat_unsigned(input logic signed [WIDE_W-1:0] v);
    logic [ACC_W-1:0] r;
    if (v > WIDE_U_MAX) r = U_MAX;
    else if (v < 0) r = '0;
    else r = v[ACC_W-1:0];
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_signed(input logic signed [WIDE_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > WIDE_S_MAX) r = WIDE_S_MAX[ACC_W-1:0];
    else if (v < WIDE_S_MIN) r = WIDE_S_MIN[ACC_W-1:0];
    else r = v[ACC_W-1:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/stokes_parameter_integrator_unit.sv -----
// ----------------------------------------------------------------------------
// Stokes parameter integrator
// Accumulates Stokes I, Q, U, V over a window and emits the averaged sums.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one dual-polarization sample per item,
//   with station_valid (add it or skip it) and window_end (emit after it).
//   Output channel (out_valid / out_stall): one result item per window end.
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 all_stokes,
//   index 1 average_divisor (0 acts as 1). Write only while the block is idle.
// Sequencing:
//   A skipped item that does not end a window leaves the sequencer idle. For a
//   valid sample the eight cross and power products go one per cycle
//   through a single 16x16 multiply-accumulate unit, then one saturating
//   update of the sums follows (I alone when all_stokes is 0). A window end
//   runs one shared restoring divider over each sum (45 quotient bits,
//   one per cycle, plus a load and a store step per sum) and a publish step,
//   which waits for a free output slot before out_valid rises.
// Reset clears the sums, the sequencer and out_valid, and sets all_stokes=1,
// average_divisor=1. A stalled result sits in the output register; the block
// still takes items until it needs to publish the next result, then holds.
// ----------------------------------------------------------------------------
`include "stokes_parameter_integrator_unit_defines.svh"

module stokes_parameter_integrator_unit (
  input  logic                                clk,
  input  logic                                rst,
  // sample input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [spiu_pkg::SAMPLE_W-1:0] x_re,
  input  logic signed [spiu_pkg::SAMPLE_W-1:0] x_im,
  input  logic signed [spiu_pkg::SAMPLE_W-1:0] y_re,
  input  logic signed [spiu_pkg::SAMPLE_W-1:0] y_im,
  input  logic                                station_valid,
  input  logic                                window_end,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [spiu_pkg::ACC_W-1:0]          stokes_i,
  output logic signed [spiu_pkg::ACC_W-1:0]   stokes_q,
  output logic signed [spiu_pkg::ACC_W-1:0]   stokes_u,
  output logic signed [spiu_pkg::ACC_W-1:0]   stokes_v,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [spiu_pkg::DIV_W-1:0]          cfg_data
);
  import spiu_pkg::*;

  st_t   state, state_next;
  ctrl_t ctrl;

  // configuration registers
  logic             all_stokes;
  logic [DIV_W-1:0] average_divisor;
  logic [DIV_W-1:0] divisor;

  // captured item
  logic signed [SAMPLE_W-1:0] cap_x_re, cap_x_im, cap_y_re, cap_y_im;
  logic                       cap_window_end;

  // multiply-accumulate unit
  logic [MAC_W-1:0]           mac_step;
  logic signed [SAMPLE_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [TERM_W-1:0]   term;
  logic signed [TERM_W-1:0]   part [STOKES_COUNT];
  logic [LANE_W-1:0]          part_idx;

  // window sums
  logic [ACC_W-1:0]          sum_i;
  logic signed [ACC_W-1:0]   sum_q, sum_u, sum_v;
  logic signed [WIDE_W-1:0]  i_wide, q_wide, u_wide, v_wide;

  // shared divider
  logic [LANE_W-1:0]        div_lane;
  logic [DCNT_W-1:0]        div_cnt;
  logic [DIV_W-1:0]         div_rem;
  logic [ACC_W-1:0]         div_quo;
  logic                     div_neg;
  logic [ACC_W-1:0]         lane_val;
  logic                     lane_neg;
  logic [DIV_W:0]           rem_shift;
  logic                     rem_ge;
  logic [DIV_W:0]           rem_diff;
  logic [ACC_W-1:0]         res [STOKES_COUNT];

  logic slot_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = ctrl.in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign divisor   = (average_divisor == '0) ? DIV_W'(1) : average_divisor;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (station_valid) state_next = ST_MAC;
          else if (window_end) state_next = ST_DIV_LOAD;
        end
      end
      ST_MAC: begin
        if (mac_step == MAC_W'(MAC_STEPS-1)) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_next = cap_window_end ? ST_DIV_LOAD : ST_IDLE;
      end
      ST_DIV_LOAD: begin
        state_next = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (div_cnt == DCNT_W'(DIV_STEPS-1)) state_next = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        state_next = (div_lane == LANE_W'(STOKES_COUNT-1)) ? ST_PUBLISH : ST_DIV_LOAD;
      end
      ST_PUBLISH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        ctrl.in_stall = 1'b0;
        ctrl.accept   = in_valid;
      end
      ST_MAC:       ctrl.mac_en    = 1'b1;
      ST_ACCUM:     ctrl.accum_en  = 1'b1;
      ST_DIV_LOAD:  ctrl.div_load  = 1'b1;
      ST_DIV_RUN:   ctrl.div_step  = 1'b1;
      ST_DIV_STORE: ctrl.div_store = 1'b1;
      ST_PUBLISH:   ctrl.publish   = slot_free;
      default:      ctrl.in_stall  = 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      all_stokes      <= 1'b1;
      average_divisor <= DIV_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALL_STOKES: all_stokes      <= cfg_data[0];
        REG_DIVISOR:    average_divisor <= cfg_data;
        default:        all_stokes      <= all_stokes;
      endcase
    end
  end

  // Hold the item for the whole pass.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cap_x_re       <= x_re;
      cap_x_im       <= x_im;
      cap_y_re       <= y_re;
      cap_y_im       <= y_im;
      cap_window_end <= window_end;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply-accumulate: pairs of products land in one partial each.
  //   part 0 = |X|^2, part 1 = |Y|^2, part 2 = Re(X conj Y), part 3 = Im(X conj Y)
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (mac_step)
      3'd0:    begin op_a = cap_x_re; op_b = cap_x_re; end
      3'd1:    begin op_a = cap_x_im; op_b = cap_x_im; end
      3'd2:    begin op_a = cap_y_re; op_b = cap_y_re; end
      3'd3:    begin op_a = cap_y_im; op_b = cap_y_im; end
      3'd4:    begin op_a = cap_x_re; op_b = cap_y_re; end
      3'd5:    begin op_a = cap_x_im; op_b = cap_y_im; end
      3'd6:    begin op_a = cap_x_im; op_b = cap_y_re; end
      default: begin op_a = cap_x_re; op_b = cap_y_im; end
    endcase
  end

  assign prod     = op_a * op_b;
  // The last product enters V with a minus sign.
  assign term     = (mac_step == MAC_W'(MAC_STEPS-1)) ? -TERM_W'(prod) : TERM_W'(prod);
  assign part_idx = mac_step[MAC_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_step <= '0;
    end else if (ctrl.mac_en) begin
      mac_step <= mac_step + MAC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mac_en) begin
      if (mac_step[0]) part[part_idx] <= part[part_idx] + term;
      else part[part_idx] <= term;
    end
  end

  // --------------------------------------------------------------------------
  // Saturating window sums
  // --------------------------------------------------------------------------
  assign i_wide = $signed({2'b00, sum_i}) + WIDE_W'(part[0]) + WIDE_W'(part[1]);
  assign q_wide = WIDE_W'(sum_q) + WIDE_W'(part[0]) - WIDE_W'(part[1]);
  assign u_wide = WIDE_W'(sum_u) + WIDE_W'(part[2]);
  assign v_wide = WIDE_W'(sum_v) + WIDE_W'(part[3]);

  always_ff @(posedge clk) begin
    if (rst || ctrl.publish) begin
      sum_i <= '0;
      sum_q <= '0;
      sum_u <= '0;
      sum_v <= '0;
    end else if (ctrl.accum_en) begin
      sum_i <= sat_unsigned(i_wide);
      if (all_stokes) begin
        sum_q <= sat_signed(q_wide);
        sum_u <= sat_signed(u_wide);
        sum_v <= sat_signed(v_wide);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared divider: magnitude restoring division, one quotient bit a cycle,
  // sign restored at store so the quotient truncates toward zero.
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (div_lane)
      2'd0:    lane_val = sum_i;
      2'd1:    lane_val = sum_q;
      2'd2:    lane_val = sum_u;
      default: lane_val = sum_v;
    endcase
  end

  assign lane_neg  = (div_lane != '0) && lane_val[ACC_W-1];
  assign rem_shift = {div_rem, div_quo[ACC_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_lane <= '0;
      div_cnt  <= '0;
    end else begin
      if (ctrl.div_load) div_cnt <= '0;
      else if (ctrl.div_step) div_cnt <= div_cnt + DCNT_W'(1);
      if (ctrl.div_store) div_lane <= div_lane + LANE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      div_rem <= '0;
      div_neg <= lane_neg;
      div_quo <= lane_neg ? -lane_val : lane_val;
    end else if (ctrl.div_step) begin
      div_rem <= rem_ge ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
      div_quo <= {div_quo[ACC_W-2:0], rem_ge};
    end
    if (ctrl.div_store) begin
      res[div_lane] <= div_neg ? -div_quo : div_quo;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: load when the slot is free, drop valid once taken.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.publish) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.publish) begin
      stokes_i <= res[0];
      stokes_q <= all_stokes ? res[1] : '0;
      stokes_u <= all_stokes ? res[2] : '0;
      stokes_v <= all_stokes ? res[3] : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SPIU_ASSERT_IMP(a_publish_free, ctrl.publish, (!out_valid || !out_stall), "result overwrite")
  `SPIU_ASSERT_NXT(a_clear_sums, ctrl.publish,
    (sum_i == '0 && sum_q == '0 && sum_u == '0 && sum_v == '0), "sums not cleared")
  `SPIU_ASSERT_IMP(a_rise_from_publish, $rose(out_valid),
    ($past(state) == ST_PUBLISH), "stray result")

endmodule

// ----- tb/sv/stokes_parameter_integrator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Stokes parameter integrator testbench
// Streams dual-polarization samples through the integrator under several
// register settings and idle mixes, predicts each averaged I/Q/U/V result
// in exact integer arithmetic, and checks every result item in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spiu_pkg::*;

  // Exact accumulator limits: I is unsigned 45 bits, Q/U/V signed 45 bits.
  localparam longint I_MAX = (64'sd1 <<< ACC_W) - 1;
  localparam longint S_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint S_MIN = -(64'sd1 <<< (ACC_W - 1));

  // Settle past both a closing sample's pass and a plain sample's pass.
  localparam int SETTLE_CYCLES = 250;
  localparam int PHASE_ITEMS   = 215;
  localparam int CYCLE_LIMIT   = 3000000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] x_re;
    logic signed [SAMPLE_W-1:0] x_im;
    logic signed [SAMPLE_W-1:0] y_re;
    logic signed [SAMPLE_W-1:0] y_im;
    logic                       station_valid;
    logic                       window_end;
  } sample_t;

  typedef struct {
    logic        [ACC_W-1:0] i;
    logic signed [ACC_W-1:0] q;
    logic signed [ACC_W-1:0] u;
    logic signed [ACC_W-1:0] v;
  } stokes_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Block ports, all driven to known values from time zero
  logic                       in_valid      = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] x_re          = '0;
  logic signed [SAMPLE_W-1:0] x_im          = '0;
  logic signed [SAMPLE_W-1:0] y_re          = '0;
  logic signed [SAMPLE_W-1:0] y_im          = '0;
  logic                       station_valid = 1'b0;
  logic                       window_end    = 1'b0;
  logic                       out_valid;
  logic                       out_stall     = 1'b0;
  logic        [ACC_W-1:0]    stokes_i;
  logic signed [ACC_W-1:0]    stokes_q;
  logic signed [ACC_W-1:0]    stokes_u;
  logic signed [ACC_W-1:0]    stokes_v;
  logic                       cfg_valid     = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index     = 1'b0;
  logic [DIV_W-1:0]           cfg_data      = '0;

  stokes_parameter_integrator_unit uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .x_re          (x_re),
    .x_im          (x_im),
    .y_re          (y_re),
    .y_im          (y_im),
    .station_valid (station_valid),
    .window_end    (window_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stokes_i      (stokes_i),
    .stokes_q      (stokes_q),
    .stokes_u      (stokes_u),
    .stokes_v      (stokes_v),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Traffic bookkeeping
  sample_t sample_queue[$];
  stokes_t expected_stokes[$];
  sample_t in_flight;
  int      items_queued    = 0;
  int      items_accepted  = 0;
  int      results_checked = 0;
  int      reg_writes      = 0;
  int      fail_count      = 0;
  int      cycle_count     = 0;
  int      sender_idle_pct = 0;
  int      recv_stall_pct  = 0;
  bit      drain_hold      = 1'b0;

  // Predictor state: register copies and the four running sums
  bit               all_stokes_cfg = 1'b1;
  logic [DIV_W-1:0] divisor_cfg    = DIV_W'(1);
  longint           acc_i          = 0;
  longint           acc_q          = 0;
  longint           acc_u          = 0;
  longint           acc_v          = 0;

  function automatic longint clip(input longint val, input longint lo, input longint hi);
    if (val < lo) return lo;
    if (val > hi) return hi;
    return val;
  endfunction

  // Fold one accepted sample into the sums; on a window end, queue the
  // averaged result and clear the sums.
  function automatic void integrate_sample(input sample_t s);
    longint  xr, xi, yr, yi, px, py, d;
    stokes_t r;
    xr = s.x_re;
    xi = s.x_im;
    yr = s.y_re;
    yi = s.y_im;
    if (s.station_valid) begin
      px = xr * xr + xi * xi;
      py = yr * yr + yi * yi;
      acc_i = clip(acc_i + px + py, 0, I_MAX);
      if (all_stokes_cfg) begin
        acc_q = clip(acc_q + (px - py), S_MIN, S_MAX);
        acc_u = clip(acc_u + (xr * yr + xi * yi), S_MIN, S_MAX);
        acc_v = clip(acc_v + (xi * yr - xr * yi), S_MIN, S_MAX);
      end
    end
    if (s.window_end) begin
      d = divisor_cfg;
      if (d == 0) d = 1;
      // longint division truncates toward zero, as the block must
      r.i = ACC_W'(acc_i / d);
      if (all_stokes_cfg) begin
        r.q = ACC_W'(acc_q / d);
        r.u = ACC_W'(acc_u / d);
        r.v = ACC_W'(acc_v / d);
      end else begin
        r.q = '0;
        r.u = '0;
        r.v = '0;
      end
      expected_stokes.push_back(r);
      acc_i = 0;
      acc_q = 0;
      acc_u = 0;
      acc_v = 0;
    end
  endfunction

  // Sample values weighted toward full scale, zero, minus one and small values
  function automatic logic signed [SAMPLE_W-1:0] pick_value();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = '0;
      3: v = '1;
      4, 5: begin
        v = SAMPLE_W'($urandom_range(255));
        v = v - 16'sd128;
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.x_re          = pick_value();
    s.x_im          = pick_value();
    s.y_re          = pick_value();
    s.y_im          = pick_value();
    s.station_valid = ($urandom_range(99) < 85);
    s.window_end    = 1'b0;
    return s;
  endfunction

  function automatic sample_t mk(input int xr, input int xi, input int yr, input int yi,
                                 input bit sv, input bit we);
    sample_t s;
    s.x_re          = SAMPLE_W'(xr);
    s.x_im          = SAMPLE_W'(xi);
    s.y_re          = SAMPLE_W'(yr);
    s.y_im          = SAMPLE_W'(yi);
    s.station_valid = sv;
    s.window_end    = we;
    return s;
  endfunction

  task automatic push_item(input sample_t s);
    sample_queue.push_back(s);
    items_queued++;
  endtask

  // Block until every queued item is taken and every result has come out,
  // then let the sequencer settle. Poll on the falling edge to stay clear
  // of the rising-edge updates.
  task automatic wait_idle();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_stokes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [DIV_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ALL_STOKES) all_stokes_cfg = val[0];
    else divisor_cfg = val;
    reg_writes++;
  endtask

  task automatic configure(input bit all_stokes, input logic [DIV_W-1:0] divisor);
    wait_idle();
    write_reg(REG_ALL_STOKES, {{(DIV_W-1){1'b0}}, all_stokes});
    write_reg(REG_DIVISOR, divisor);
  endtask

  // Move to the falling edge, then set the idle mix for what follows
  task automatic begin_traffic(input int sender_pct, input int recv_pct);
    @(negedge clk);
    sender_idle_pct = sender_pct;
    recv_stall_pct  = recv_pct;
  endtask

  // Mostly short windows with a few long ones; the last window may stay
  // open into the next phase, so register changes land mid-window too.
  task automatic queue_random_items(input int count);
    int      left, len, k;
    sample_t s;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) len = $urandom_range(300, 60);
      else len = $urandom_range(30, 1);
      for (k = 0; k < len && left > 0; k++) begin
        s = random_sample();
        s.window_end = (k == len - 1);
        push_item(s);
        left--;
      end
    end
  endtask

  // Input driver: advance on acceptance, hold while stalled, idle at random.
  // After some window ends, hold off until every result has come back.
  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    bit      take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = 1'b0;
      if (in_valid && !in_stall) begin
        integrate_sample(in_flight);
        items_accepted++;
        if (in_flight.window_end && $urandom_range(7) == 0) drain_hold = 1'b1;
      end
      if (drain_hold && expected_stokes.size() == 0) drain_hold = 1'b0;
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() > 0 && !drain_hold &&
            $urandom_range(99) >= sender_idle_pct) begin
          nxt  = sample_queue.pop_front();
          take = 1'b1;
        end
        in_valid <= take;
        if (take) begin
          in_flight     = nxt;
          x_re          <= nxt.x_re;
          x_im          <= nxt.x_im;
          y_re          <= nxt.y_re;
          y_im          <= nxt.y_im;
          station_valid <= nxt.station_valid;
          window_end    <= nxt.window_end;
        end
      end
    end
  end

  // Result monitor: check each accepted result against the oldest
  // expectation, and stall at random.
  always @(posedge clk) begin : check_results
    stokes_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_stokes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result I=%0d Q=%0d U=%0d V=%0d",
                     stokes_i, stokes_q, stokes_u, stokes_v);
        end else begin
          want = expected_stokes.pop_front();
          if (stokes_i !== want.i || stokes_q !== want.q ||
              stokes_u !== want.u || stokes_v !== want.v) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: want I=%0d Q=%0d U=%0d V=%0d got I=%0d Q=%0d U=%0d V=%0d",
                       results_checked, want.i, want.q, want.u, want.v,
                       stokes_i, stokes_q, stokes_u, stokes_v);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_stokes.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : run_test
    int p, sender, recv;
    logic [DIV_W-1:0] div;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset settings (all four, divisor 1)
    begin_traffic(0, 0);
    push_item(mk(-32768, -32768, 32767, 32767, 1'b1, 1'b0));
    push_item(mk(32767, 32767, -32768, -32768, 1'b1, 1'b1));
    // skipped sample with extreme values, then a small one closes
    push_item(mk(32767, -32768, -32768, 32767, 1'b0, 1'b0));
    push_item(mk(-1, 1, 1, -1, 1'b1, 1'b1));
    // window holding only a skipped sample
    push_item(mk(-32768, 32767, -32768, 32767, 1'b0, 1'b1));
    // skipped sample closing a window still emits and clears
    push_item(mk(123, -45, -678, 9, 1'b1, 1'b0));
    push_item(mk(-32768, -32768, -32768, -32768, 1'b0, 1'b1));
    push_item(mk(0, 0, 0, 0, 1'b1, 1'b1));

    // I only, divisor zero acts as one
    configure(1'b0, 7'd0);
    begin_traffic(0, 0);
    push_item(mk(-32768, 32767, 5, -7, 1'b1, 1'b0));
    push_item(mk(4321, -1234, 32767, -32768, 1'b1, 1'b1));

    // largest divisor, negative sums truncate toward zero
    configure(1'b1, 7'd127);
    begin_traffic(0, 0);
    push_item(mk(-32768, -32768, -32768, -32768, 1'b1, 1'b0));
    push_item(mk(1000, -2000, -3000, 4000, 1'b1, 1'b1));
    push_item(mk(0, 0, -300, -5, 1'b1, 1'b1));

    // divisor above the nominal range; leave a window open across writes
    wait_idle();
    write_reg(REG_DIVISOR, 7'd65);
    begin_traffic(0, 0);
    push_item(mk(32767, 0, 0, -32768, 1'b1, 1'b1));
    push_item(mk(200, 300, -400, 50, 1'b1, 1'b0));

    // switch to I only mid-window: Q, U, V come out zero
    wait_idle();
    write_reg(REG_ALL_STOKES, 7'd0);
    begin_traffic(0, 0);
    push_item(mk(-700, 800, 900, -100, 1'b1, 1'b1));
    push_item(mk(32767, 32767, 1, 2, 1'b1, 1'b0));

    // back to all four mid-window: Q, U, V hold only the later sample
    wait_idle();
    write_reg(REG_ALL_STOKES, 7'd1);
    begin_traffic(0, 0);
    push_item(mk(-5000, 6000, 7000, -8000, 1'b1, 1'b1));

    // Random phases over the four idle mixes and a spread of settings
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin sender = 0;  recv = 0;  end
        1: begin sender = 69; recv = 0;  end
        2: begin sender = 0;  recv = 69; end
        default: begin sender = 33; recv = 33; end
      endcase
      case (p)
        0: div = 7'd127;
        1: div = 7'd1;
        2: div = 7'd64;
        3: div = 7'd0;
        4: div = 7'd65;
        5: div = 7'd3;
        6: div = 7'd1;
        default: div = DIV_W'($urandom_range(127));
      endcase
      configure((p % 3) != 1, div);
      begin_traffic(sender, recv);
      queue_random_items(PHASE_ITEMS);
    end

    // Close any window left open by the last phase
    configure(1'b1, 7'd1);
    begin_traffic(0, 0);
    push_item(mk(0, 0, 0, 0, 1'b0, 1'b1));

    // Drain and settle
    wait_idle();

    $display("ran %0d samples into %0d averaged results over %0d register writes",
             items_accepted, results_checked, reg_writes);
    $display("idle mixes: none, sender, receiver, both; windows of 1 to 300 samples");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failing results", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
